FILE: rtl/skvt_pkg.sv
// shared types, codes and helpers for the sorted key/value table
`timescale 1ns / 1ps
package skvt_pkg;

   localparam int DEFAULT_CAPACITY = 256;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_FREEZE = 3'd1;
   localparam logic [2:0] ACT_LOOKUP = 3'd2;
   localparam logic [2:0] ACT_WRITE  = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;
   localparam logic [2:0] ACT_CLEAR  = 3'd5;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_MISS  = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_RANGE = 3'd3;
   localparam logic [2:0] ST_PHASE = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] key;
      logic [63:0] value;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  found_position;
      logic [31:0] entry_key;
      logic [63:0] entry_value;
      logic [8:0]  entries_used;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [63:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      CELL_IDLE,
      CELL_INSERT,
      CELL_WRVAL,
      CELL_CLEAR,
      CELL_SORT,
      CELL_MARK,
      CELL_COMPACT,
      CELL_LOAD_KEY,
      CELL_LOAD_IDX,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        odd;
      logic [31:0] key;
      logic [63:0] value;
   } cell_ctl_type;

   // compare-exchange rule for a neighbor pair, lo sits at the lower index
   function automatic logic swap_needed(entry_type lo, entry_type hi, logic compact);
      logic res;
      if (compact) begin
         res = !lo.valid && hi.valid;
      end else begin
         res = lo.valid && hi.valid && (lo.key > hi.key);
      end
      return res;
   endfunction

endpackage

FILE: rtl/skvt_cell.sv
// one table cell: holds an entry, a duplicate token and a result slot
`timescale 1ns / 1ps
module skvt_cell
   import skvt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int INDEX    = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cell_ctl_type                ctl,
   input  logic [$clog2(CAPACITY)-1:0] tgt,
   input  entry_type                   left_entry,
   input  entry_type                   right_entry,
   input  logic                        right_dup,
   input  entry_type                   right_slot,
   output entry_type                   entry,
   output logic                        dup,
   output entry_type                   slot
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic HAS_LEFT  = (INDEX > 0);
   localparam logic HAS_RIGHT = (INDEX < CAPACITY - 1);
   localparam logic MY_PAR    = MY_IDX[0];

   entry_type entry_ff, entry_in;
   entry_type slot_ff, slot_in;
   logic      dup_ff, dup_in;
   logic      is_tgt, is_dup, hit, compact;

   assign is_tgt  = (MY_IDX == tgt);
   assign is_dup  = HAS_RIGHT && entry_ff.valid && right_entry.valid
                    && (entry_ff.key == right_entry.key);
   assign compact = (ctl.op == CELL_COMPACT);

   always_comb begin
      entry_in = entry_ff;
      slot_in  = slot_ff;
      dup_in   = dup_ff;
      hit      = 1'b0;
      case (ctl.op)
         CELL_INSERT: begin
            if (is_tgt) begin
               entry_in = '{valid: 1'b1, key: ctl.key, value: ctl.value};
            end
         end
         CELL_WRVAL: begin
            if (is_tgt) begin
               entry_in.value = ctl.value;
            end
         end
         CELL_CLEAR: begin
            entry_in.valid = 1'b0;
         end
         CELL_SORT, CELL_COMPACT: begin
            // lower cell of the pair when its parity matches the phase
            if (MY_PAR == ctl.odd) begin
               if (HAS_RIGHT && swap_needed(entry_ff, right_entry, compact)) begin
                  entry_in = right_entry;
               end
            end else begin
               if (HAS_LEFT && swap_needed(left_entry, entry_ff, compact)) begin
                  entry_in = left_entry;
               end
            end
            if (compact) begin
               dup_in = HAS_RIGHT ? right_dup : 1'b0;
            end
         end
         CELL_MARK: begin
            // equal right neighbor was inserted later, it wins
            dup_in         = is_dup;
            entry_in.valid = entry_ff.valid && !is_dup;
         end
         CELL_LOAD_KEY, CELL_LOAD_IDX: begin
            if (ctl.op == CELL_LOAD_KEY) begin
               hit = entry_ff.valid && (entry_ff.key == ctl.key);
            end else begin
               hit = entry_ff.valid && is_tgt;
            end
            slot_in = hit ? entry_ff : '0;
         end
         CELL_SHIFT: begin
            slot_in = HAS_RIGHT ? right_slot : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         slot_ff.valid  <= 1'b0;
         dup_ff         <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         slot_ff  <= slot_in;
         dup_ff   <= dup_in;
      end
   end

   assign entry = entry_ff;
   assign dup   = dup_ff;
   assign slot  = slot_ff;

endmodule

FILE: rtl/sorted_key_value_table.sv
// insert, write, clear and rejected requests answer in the cycle after acceptance
// lookup and read: the result slot shifts down the cell row to cell 0, then the response is registered
// freeze: an odd-even transposition sort, a duplicate mark step, then a compaction pass
// one request at a time; a new request is taken while the previous response is taken
// reset: synchronous, active high; empties the table and returns to the build phase
`timescale 1ns / 1ps
module sorted_key_value_table
   import skvt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PW    = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_SORT    = 6'b000010,
      S_MARK    = 6'b000100,
      S_COMPACT = 6'b001000,
      S_FIN     = 6'b010000,
      S_SCAN    = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             sealed_ff, sealed_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_ctl_type     ctl;
   logic [IDX_W-1:0] tgt;
   logic             rsp_free, accept, in_range;

   entry_type cell_entry [CAPACITY];
   entry_type cell_slot  [CAPACITY];
   logic      cell_dup   [CAPACITY];

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         entry_type left_e, right_e, right_s;
         logic      right_d;
         if (gi == 0) begin : g_first
            assign left_e = '0;
         end else begin : g_mid_l
            assign left_e = cell_entry[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_e = '0;
            assign right_s = '0;
            assign right_d = 1'b0;
         end else begin : g_mid_r
            assign right_e = cell_entry[gi+1];
            assign right_s = cell_slot[gi+1];
            assign right_d = cell_dup[gi+1];
         end
         skvt_cell #(.CAPACITY(CAPACITY), .INDEX(gi)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .tgt         (tgt),
            .left_entry  (left_e),
            .right_entry (right_e),
            .right_dup   (right_d),
            .right_slot  (right_s),
            .entry       (cell_entry[gi]),
            .dup         (cell_dup[gi]),
            .slot        (cell_slot[gi])
         );
      end
   endgenerate

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign in_range  = (PW'(req_payload.position) < PW'(used_ff));

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      sealed_in    = sealed_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.op       = CELL_IDLE;
      ctl.odd      = step_ff[0];
      ctl.key      = req_payload.key;
      ctl.value    = req_payload.value;
      tgt          = IDX_W'(req_payload.position);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               case (req_payload.action)
                  ACT_INSERT: begin
                     if (sealed_ff) begin
                        rsp_in.status = ST_PHASE;
                     end else if (used_ff == FULL_CNT) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ctl.op  = CELL_INSERT;
                        tgt     = IDX_W'(used_ff);
                        used_in = used_ff + 1'b1;
                     end
                  end
                  ACT_FREEZE: begin
                     if (!sealed_ff) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SORT;
                        step_in      = '0;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (!sealed_ff) begin
                        rsp_in.status = ST_PHASE;
                     end else begin
                        ctl.op       = CELL_LOAD_KEY;
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        step_in      = '0;
                     end
                  end
                  ACT_WRITE: begin
                     if (in_range) begin
                        ctl.op = CELL_WRVAL;
                     end else begin
                        rsp_in.status = ST_RANGE;
                     end
                  end
                  ACT_READ: begin
                     if (in_range) begin
                        ctl.op       = CELL_LOAD_IDX;
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        step_in      = '0;
                     end else begin
                        rsp_in.status = ST_RANGE;
                     end
                  end
                  ACT_CLEAR: begin
                     ctl.op    = CELL_CLEAR;
                     used_in   = '0;
                     sealed_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
               rsp_in.entries_used = 9'(used_in);
            end
         end
         S_SORT: begin
            ctl.op = CELL_SORT;
            if (step_ff == LAST_STEP) begin
               state_in = S_MARK;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MARK: begin
            ctl.op   = CELL_MARK;
            state_in = S_COMPACT;
            step_in  = '0;
         end
         S_COMPACT: begin
            // duplicate tokens drain out of cell 0, one per cycle
            ctl.op = CELL_COMPACT;
            if (cell_dup[0]) begin
               used_in = used_ff - 1'b1;
            end
            if (step_ff == LAST_STEP) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.entries_used = 9'(used_ff);
               sealed_in           = 1'b1;
               state_in            = S_IDLE;
            end
         end
         S_SCAN: begin
            // slot of cell n reaches cell 0 after n shifts
            if (cell_slot[0].valid || (step_ff == LAST_STEP)) begin
               if (rsp_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in              = '0;
                  rsp_in.entries_used = 9'(used_ff);
                  if (cell_slot[0].valid) begin
                     rsp_in.found_position = 8'(step_ff);
                     rsp_in.entry_key      = cell_slot[0].key;
                     rsp_in.entry_value    = cell_slot[0].value;
                  end else begin
                     rsp_in.status = ST_MISS;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               ctl.op  = CELL_SHIFT;
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         sealed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         sealed_ff    <= sealed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/skvt_checker.sv
// port-level checks for the sorted key/value table, bound to the top level
`timescale 1ns / 1ps
module skvt_port_checks
   import skvt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_MISS) |->
         (rsp_payload.entry_key == '0) && (rsp_payload.entry_value == '0)
         && (rsp_payload.found_position == '0))
      else $error("miss response carries entry data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL) |->
         rsp_payload.entries_used == 9'(CAPACITY))
      else $error("table full reported below capacity");

endmodule

bind sorted_key_value_table skvt_port_checks #(.CAPACITY(CAPACITY)) u_skvt_port_checks (.*);
